### design/jbr_pkg.sv
// -----------------------------------------------------------------------------
// jbr_pkg: shared definitions for the JPEG bit reader
// Function codes, sequencer states, stream field positions and defaults.
// -----------------------------------------------------------------------------
package jbr_pkg;

   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int MAX_READ_BITS_DEF = 32;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] STUFF_BYTE    = 8'h00;
   localparam logic [3:0] BYTE_BITS     = 4'd8;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 6;
   localparam int FUNC_W  = 2;

   // Request tdata layout, lowest bit first.
   localparam int REQ_DATA_LSB   = 0;
   localparam int REQ_COUNT_LSB  = 8;
   localparam int REQ_STUFF_BIT  = 14;
   localparam int REQ_TARGET_LSB = 15;
   localparam int REQ_W          = 24;

   // Response tdata layout, lowest bit first.
   localparam int RSP_VALUE_LSB  = 0;
   localparam int RSP_COUNT_LSB  = 32;
   localparam int RSP_FOUND_BIT  = 38;
   localparam int RSP_MARKER_BIT = 39;
   localparam int RSP_FULL_BIT   = 40;
   localparam int RSP_W          = 48;

   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_READ = 2'd1,
      FUNC_SKIP = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_BIT_WAIT,
      ST_FAST,
      ST_FAST_WAIT,
      ST_SKIP,
      ST_SKIP_WAIT,
      ST_DONE
   } state_type;

endpackage

### design/jbr_ram.sv
// -----------------------------------------------------------------------------
// jbr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// -----------------------------------------------------------------------------
module jbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/jpeg_bit_reader_unstuff.sv
// -----------------------------------------------------------------------------
// jpeg_bit_reader_unstuff: MSB-first JPEG entropy bit reader
// Byte queue with push, bit read with 0xFF00 unstuffing, and skip-to-byte.
// -----------------------------------------------------------------------------
// A push transfer goes straight to the done state and its response. A bit-wise
// read shifts out one bit per cycle, pausing whenever a byte is pulled from the
// queue; dropping a stuffed 0x00 costs a further fetch from the queue. The
// whole-byte fast path after a skip fetches and captures one byte at a time, and
// a skip fetches and compares each discarded byte in turn. This byte step is
// set by the registered read of the queue RAM. One transfer is worked on at a
// time; a new request is taken as soon as the previous response has moved
// into the output register, even if the consumer has not yet taken it.
module jpeg_bit_reader_unstuff #(
   parameter int QUEUE_DEPTH   = jbr_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_READ_BITS = jbr_pkg::MAX_READ_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // data_byte[7:0], bit_count[13:8], stuffing_on[14], target_byte[22:15]
   input  logic [jbr_pkg::REQ_W-1:0] req_tdata,
   // func[1:0]
   input  logic [jbr_pkg::FUNC_W-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // bits_value[31:0], bits_read[37:32], found[38], marker_seen[39],
   // queue_full[40]
   output logic [jbr_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int QAW   = $clog2(QUEUE_DEPTH);
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
   localparam int POSW  = QCW + 1;
   localparam int CNTW  = $clog2(MAX_READ_BITS + 1);
   localparam int CMPW  = (CNTW > jbr_pkg::COUNT_W) ? CNTW : jbr_pkg::COUNT_W;
   localparam int VW    = jbr_pkg::VALUE_W;

   jbr_pkg::state_type state_ff, state_in;

   logic [QAW-1:0]  head_ff, head_in;
   logic [QCW-1:0]  count_ff, count_in;
   logic [7:0]      current_ff, current_in;
   logic [3:0]      bit_index_ff, bit_index_in;
   logic [VW-1:0]   value_ff, value_in;
   logic [CNTW-1:0] got_ff, got_in;
   logic [CNTW-1:0] rem_ff, rem_in;
   logic            stuff_ff, stuff_in;
   logic [7:0]      target_ff, target_in;
   logic            ff_pend_ff, ff_pend_in;
   logic            found_ff, found_in;
   logic            marker_ff, marker_in;
   logic            full_ff, full_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [jbr_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic            ram_we;
   logic [QAW-1:0]  ram_waddr;
   logic            ram_re;
   logic [7:0]      ram_rdata;

   logic [7:0]      req_data;
   logic [5:0]      req_count;
   logic            req_stuff;
   logic [7:0]      req_target;
   logic [CMPW-1:0] count_cmp;
   logic [CNTW-1:0] count_sat;
   logic [QAW-1:0]  head_next;
   logic [POSW-1:0] push_pos;
   logic [2:0]      bit_sel;
   logic            accept;

   assign req_data   = req_tdata[jbr_pkg::REQ_DATA_LSB +: 8];
   assign req_count  = req_tdata[jbr_pkg::REQ_COUNT_LSB +: 6];
   assign req_stuff  = req_tdata[jbr_pkg::REQ_STUFF_BIT];
   assign req_target = req_tdata[jbr_pkg::REQ_TARGET_LSB +: 8];

   assign count_cmp = (CMPW'(req_count) > CMPW'(MAX_READ_BITS)) ?
                      CMPW'(MAX_READ_BITS) : CMPW'(req_count);
   assign count_sat = CNTW'(count_cmp);

   assign head_next = (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign push_pos  = POSW'(head_ff) + POSW'(count_ff);
   assign ram_waddr = (push_pos >= POSW'(QUEUE_DEPTH)) ?
                      QAW'(push_pos - POSW'(QUEUE_DEPTH)) : QAW'(push_pos);
   assign bit_sel   = 3'(bit_index_ff - 4'd1);

   assign req_tready = (state_ff == jbr_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   jbr_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      current_in   = current_ff;
      bit_index_in = bit_index_ff;
      value_in     = value_ff;
      got_in       = got_ff;
      rem_in       = rem_ff;
      stuff_in     = stuff_ff;
      target_in    = target_ff;
      ff_pend_in   = ff_pend_ff;
      found_in     = found_ff;
      marker_in    = marker_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         jbr_pkg::ST_IDLE: begin
            if (accept) begin
               value_in   = '0;
               got_in     = '0;
               found_in   = 1'b0;
               marker_in  = 1'b0;
               full_in    = 1'b0;
               ff_pend_in = 1'b0;
               stuff_in   = req_stuff;
               target_in  = req_target;
               state_in   = jbr_pkg::ST_DONE;
               unique case (jbr_pkg::func_type'(req_tuser))
                  jbr_pkg::FUNC_PUSH: begin
                     if (count_ff < QCW'(QUEUE_DEPTH)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  jbr_pkg::FUNC_READ: begin
                     if (count_sat != '0) begin
                        if (!req_stuff && bit_index_ff == jbr_pkg::BYTE_BITS &&
                            count_sat[2:0] == 3'd0) begin
                           // Whole-byte read: the held byte leads, then queue bytes.
                           value_in     = VW'(current_ff);
                           got_in       = count_sat;
                           rem_in       = CNTW'(count_sat >> 3) - 1'b1;
                           bit_index_in = '0;
                           state_in     = jbr_pkg::ST_FAST;
                        end else begin
                           rem_in   = count_sat;
                           state_in = jbr_pkg::ST_BIT;
                        end
                     end
                  end
                  jbr_pkg::FUNC_SKIP: begin
                     state_in = jbr_pkg::ST_SKIP;
                  end
                  jbr_pkg::FUNC_NOP: begin
                     state_in = jbr_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = jbr_pkg::ST_DONE;
                  end
               endcase
            end
         end

         jbr_pkg::ST_BIT: begin
            if (rem_ff == '0) begin
               state_in = jbr_pkg::ST_DONE;
            end else if (bit_index_ff != '0) begin
               bit_index_in = bit_index_ff - 1'b1;
               value_in     = {value_ff[VW-2:0], current_ff[bit_sel]};
               got_in       = got_ff + 1'b1;
               rem_in       = rem_ff - 1'b1;
            end else begin
               ff_pend_in = stuff_ff && (current_ff == jbr_pkg::MARKER_PREFIX);
               if (count_ff == '0) begin
                  // Ran dry: the read ends short.
                  current_in = '0;
                  state_in   = jbr_pkg::ST_DONE;
               end else begin
                  ram_re   = 1'b1;
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
                  state_in = jbr_pkg::ST_BIT_WAIT;
               end
            end
         end

         jbr_pkg::ST_BIT_WAIT: begin
            current_in = ram_rdata;
            if (ff_pend_ff) begin
               ff_pend_in = 1'b0;
               if (ram_rdata != jbr_pkg::STUFF_BYTE) begin
                  marker_in = 1'b1;
                  state_in  = jbr_pkg::ST_DONE;
               end else if (count_ff == '0) begin
                  current_in = '0;
                  state_in   = jbr_pkg::ST_DONE;
               end else begin
                  // Drop the stuffed zero and fetch the byte after it.
                  ram_re   = 1'b1;
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
               end
            end else begin
               bit_index_in = jbr_pkg::BYTE_BITS;
               state_in     = jbr_pkg::ST_BIT;
            end
         end

         jbr_pkg::ST_FAST: begin
            if (rem_ff == '0) begin
               state_in = jbr_pkg::ST_DONE;
            end else if (count_ff == '0) begin
               value_in = {value_ff[VW-9:0], 8'h00};
               got_in   = '0;
               rem_in   = rem_ff - 1'b1;
            end else begin
               ram_re   = 1'b1;
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               state_in = jbr_pkg::ST_FAST_WAIT;
            end
         end

         jbr_pkg::ST_FAST_WAIT: begin
            value_in = {value_ff[VW-9:0], ram_rdata};
            rem_in   = rem_ff - 1'b1;
            state_in = jbr_pkg::ST_FAST;
         end

         jbr_pkg::ST_SKIP: begin
            if (current_ff == target_ff) begin
               found_in     = 1'b1;
               bit_index_in = jbr_pkg::BYTE_BITS;
               state_in     = jbr_pkg::ST_DONE;
            end else if (count_ff == '0) begin
               current_in   = '0;
               bit_index_in = '0;
               state_in     = jbr_pkg::ST_DONE;
            end else begin
               ram_re   = 1'b1;
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               state_in = jbr_pkg::ST_SKIP_WAIT;
            end
         end

         jbr_pkg::ST_SKIP_WAIT: begin
            current_in = ram_rdata;
            state_in   = jbr_pkg::ST_SKIP;
         end

         jbr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, full_ff, marker_ff, found_ff,
                               jbr_pkg::COUNT_W'(got_ff), value_ff};
               state_in     = jbr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = jbr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jbr_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         current_ff   <= '0;
         bit_index_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         bit_index_ff <= bit_index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      got_ff      <= got_in;
      rem_ff      <= rem_in;
      stuff_ff    <= stuff_in;
      target_ff   <= target_in;
      ff_pend_ff  <= ff_pend_in;
      found_ff    <= found_in;
      marker_ff   <= marker_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/jbr_checker.sv
// -----------------------------------------------------------------------------
// jbr_checker: port-level checks for the JPEG bit reader
// Watches the request and response streams and is bound to the top level.
// -----------------------------------------------------------------------------
module jbr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [jbr_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready
);

   // A response that has not been taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Only one kind of status can be reported by a single transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[jbr_pkg::RSP_FULL_BIT],
                               rsp_tdata[jbr_pkg::RSP_MARKER_BIT],
                               rsp_tdata[jbr_pkg::RSP_FOUND_BIT]}))
      else $error("more than one status flag set");

   // Queue-full push and found skip results carry no bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[jbr_pkg::RSP_FULL_BIT] ||
                     rsp_tdata[jbr_pkg::RSP_FOUND_BIT])
      |-> rsp_tdata[jbr_pkg::RSP_COUNT_LSB +: jbr_pkg::COUNT_W] == '0 &&
          rsp_tdata[jbr_pkg::RSP_VALUE_LSB +: jbr_pkg::VALUE_W] == '0)
      else $error("push or skip returned read data");

   // A request taken on one edge cannot be answered on the next.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !(rsp_tvalid && !rsp_tready)
      |=> !rsp_tvalid)
      else $error("response appeared without processing time");

endmodule

bind jpeg_bit_reader_unstuff jbr_checker u_jbr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

### tb/jpeg_bit_reader_unstuff_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jpeg_bit_reader_unstuff_tb: self-checking bench for the JPEG bit reader
// Streams push, read, skip and no-op commands through the request channel,
// predicts every reply with a cycle-free model of the byte queue and bit
// pointer, and checks each reply field by field under random back-pressure.
// -----------------------------------------------------------------------------
module jpeg_bit_reader_unstuff_tb;

   localparam int DEPTH     = jbr_pkg::QUEUE_DEPTH_DEF;
   localparam int MAX_BITS  = jbr_pkg::MAX_READ_BITS_DEF;
   localparam int PER_PHASE = 600;
   localparam int DRAIN_CYCLES = 64;
   localparam int BIT_MARKER = -1;
   localparam int BIT_DRY    = -2;

   typedef struct {
      jbr_pkg::func_type func;
      logic [7:0]        data;
      logic [5:0]        count;
      logic              stuff;
      logic [7:0]        target;
   } reader_cmd_type;

   typedef struct {
      logic [31:0] value;
      logic [5:0]  nbits;
      logic        found;
      logic        marker;
      logic        full;
   } reader_reply_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [jbr_pkg::REQ_W-1:0]     req_tdata = '0;
   logic [jbr_pkg::FUNC_W-1:0]    req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [jbr_pkg::RSP_W-1:0]     rsp_tdata;

   reader_cmd_type   cmd_queue[$];
   reader_reply_type reply_queue[$];
   reader_cmd_type   held_cmd;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               mismatches = 0;
   int               cmds_added = 0;

   // Predicted state of the reader.
   logic [7:0] fifo_mem [DEPTH];
   int         fifo_head;
   int         fifo_level;
   logic [7:0] work_byte;
   logic [3:0] bits_left;

   jpeg_bit_reader_unstuff dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] pop_byte(inout bit dry);
      logic [7:0] b;
      if (fifo_level == 0) begin
         dry = 1'b1;
         return 8'h00;
      end
      b = fifo_mem[fifo_head];
      fifo_head = (fifo_head + 1 >= DEPTH) ? 0 : fifo_head + 1;
      fifo_level--;
      return b;
   endfunction

   function automatic int pull_bit(bit stuff);
      bit         dry;
      logic [7:0] prev;
      dry = 1'b0;
      if (bits_left == 0) begin
         prev = work_byte;
         work_byte = pop_byte(dry);
         // A 0xFF followed by anything other than a stuffed zero is a marker.
         if (stuff && prev == jbr_pkg::MARKER_PREFIX) begin
            if (work_byte != jbr_pkg::STUFF_BYTE) return BIT_MARKER;
            work_byte = pop_byte(dry);
         end
         if (dry) return BIT_DRY;
         bits_left = jbr_pkg::BYTE_BITS;
      end
      bits_left--;
      return int'(work_byte[bits_left]);
   endfunction

   function automatic reader_reply_type reader_step(reader_cmd_type c);
      reader_reply_type r;
      int               n;
      int               b;
      int               k;
      int               pos;
      bit               dry;
      bit               stop;
      logic [63:0]      acc;
      r = '{default: '0};
      acc = '0;
      dry = 1'b0;
      stop = 1'b0;
      case (c.func)
         jbr_pkg::FUNC_PUSH: begin
            if (fifo_level < DEPTH) begin
               pos = fifo_head + fifo_level;
               if (pos >= DEPTH) pos -= DEPTH;
               fifo_mem[pos] = c.data;
               fifo_level++;
            end else begin
               r.full = 1'b1;
            end
         end
         jbr_pkg::FUNC_READ: begin
            n = (c.count > MAX_BITS) ? MAX_BITS : int'(c.count);
            if (n != 0) begin
               if (c.stuff || bits_left != jbr_pkg::BYTE_BITS || n % 8 != 0) begin
                  for (k = 0; k < n && !stop; k++) begin
                     b = pull_bit(c.stuff);
                     if (b < 0) begin
                        r.marker = (b == BIT_MARKER);
                        stop = 1'b1;
                     end else begin
                        acc = {acc[62:0], b[0]};
                        r.nbits++;
                     end
                  end
               end else begin
                  // Whole-byte path: the current byte leads, the queue supplies the rest.
                  acc = {56'd0, work_byte};
                  for (k = 8; k < n; k += 8) acc = {acc[55:0], pop_byte(dry)};
                  bits_left = '0;
                  r.nbits = dry ? 6'd0 : n[5:0];
               end
            end
            r.value = acc[31:0];
         end
         jbr_pkg::FUNC_SKIP: begin
            while (work_byte != c.target && !dry) work_byte = pop_byte(dry);
            if (!dry) begin
               bits_left = jbr_pkg::BYTE_BITS;
               r.found = 1'b1;
            end else begin
               work_byte = 8'h00;
               bits_left = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_cmd(jbr_pkg::func_type f, int data, int count, bit stuff, int target);
      reader_cmd_type c;
      c.func = f;
      c.data = data[7:0];
      c.count = count[5:0];
      c.stuff = stuff;
      c.target = target[7:0];
      cmd_queue.push_back(c);
      if (f != jbr_pkg::FUNC_NOP) cmds_added++;
   endtask

   task automatic push_byte(int b);
      add_cmd(jbr_pkg::FUNC_PUSH, b, $urandom_range(0, 63), $urandom_range(0, 1),
              $urandom_range(0, 255));
   endtask

   task automatic read_bits(int count, bit stuff);
      add_cmd(jbr_pkg::FUNC_READ, $urandom_range(0, 255), count, stuff,
              $urandom_range(0, 255));
   endtask

   task automatic skip_to(int target, bit stuff);
      add_cmd(jbr_pkg::FUNC_SKIP, $urandom_range(0, 255), $urandom_range(0, 63), stuff,
              target);
   endtask

   // One short, mostly well-formed command sequence with random content.
   task automatic add_burst();
      int kind;
      int k;
      int i;
      int sel;
      int t;
      int total;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         // Entropy-coded segment: stuffed 0xFF bytes, the odd marker, stuffed reads.
         k = $urandom_range(1, 7);
         for (i = 0; i < k; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
               push_byte(jbr_pkg::MARKER_PREFIX);
               push_byte(jbr_pkg::STUFF_BYTE);
            end else if (sel == 2) begin
               push_byte(jbr_pkg::MARKER_PREFIX);
               push_byte($urandom_range(1, 255));
            end else begin
               push_byte($urandom_range(0, 255));
            end
         end
         total = 0;
         while (total < 8 * k) begin
            sel = $urandom_range(1, 32);
            read_bits(sel, $urandom_range(0, 9) != 0);
            total += sel;
         end
      end else if (kind < 50) begin
         // Skip to a known byte, then mostly whole-byte reads.
         t = $urandom_range(0, 255);
         k = $urandom_range(0, 4);
         for (i = 0; i < k; i++) push_byte($urandom_range(0, 255));
         push_byte(t);
         k = $urandom_range(0, 5);
         for (i = 0; i < k; i++) push_byte($urandom_range(0, 255));
         skip_to(t, $urandom_range(0, 1));
         sel = $urandom_range(0, 9);
         if (sel < 7) read_bits(8 * $urandom_range(1, 4), 1'b0);
         else if (sel < 9) read_bits(8 * $urandom_range(5, 7), 1'b0);
         else read_bits($urandom_range(1, 63), $urandom_range(0, 1));
         if ($urandom_range(0, 1)) read_bits($urandom_range(0, 32), $urandom_range(0, 1));
      end else if (kind < 65) begin
         // Fill the queue, often past full, then drain it with wide reads.
         k = $urandom_range(14, 20);
         for (i = 0; i < k; i++) push_byte($urandom_range(0, 255));
         k = $urandom_range(2, 5);
         for (i = 0; i < k; i++) read_bits($urandom_range(24, 63), $urandom_range(0, 1));
      end else if (kind < 80) begin
         // Starved reads and skips.
         k = $urandom_range(1, 3);
         for (i = 0; i < k; i++) read_bits($urandom_range(0, 63), $urandom_range(0, 1));
         skip_to($urandom_range(0, 255), $urandom_range(0, 1));
      end else begin
         k = $urandom_range(1, 4);
         for (i = 0; i < k; i++)
            add_cmd(jbr_pkg::func_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                    $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 255));
      end
   endtask

   // Request driver: a new transfer may be offered once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) reply_queue.push_back(reader_step(held_cmd));
         if (!req_tvalid || req_tready) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               held_cmd = cmd_queue.pop_front();
               req_tvalid <= 1'b1;
               // Padding bit 23 stays zero.
               req_tdata <= {1'b0, held_cmd.target, held_cmd.stuff, held_cmd.count,
                             held_cmd.data};
               req_tuser <= held_cmd.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Reply monitor.
   always @(posedge clock) begin
      reader_reply_type exp_r;
      reader_reply_type got_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_r.value  = rsp_tdata[jbr_pkg::RSP_VALUE_LSB +: jbr_pkg::VALUE_W];
         got_r.nbits  = rsp_tdata[jbr_pkg::RSP_COUNT_LSB +: jbr_pkg::COUNT_W];
         got_r.found  = rsp_tdata[jbr_pkg::RSP_FOUND_BIT];
         got_r.marker = rsp_tdata[jbr_pkg::RSP_MARKER_BIT];
         got_r.full   = rsp_tdata[jbr_pkg::RSP_FULL_BIT];
         if (reply_queue.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: reply with nothing expected: value=%h bits=%0d f=%b m=%b q=%b",
                        got_r.value, got_r.nbits, got_r.found, got_r.marker, got_r.full);
            mismatches++;
         end else begin
            exp_r = reply_queue.pop_front();
            if (got_r.value !== exp_r.value || got_r.nbits !== exp_r.nbits ||
                got_r.found !== exp_r.found || got_r.marker !== exp_r.marker ||
                got_r.full !== exp_r.full) begin
               if (mismatches < 10)
                  $display({"ERROR: reply mismatch: expected value=%h bits=%0d f=%b m=%b q=%b,",
                            " got value=%h bits=%0d f=%b m=%b q=%b"},
                           exp_r.value, exp_r.nbits, exp_r.found, exp_r.marker, exp_r.full,
                           got_r.value, got_r.nbits, got_r.found, got_r.marker, got_r.full);
               mismatches++;
            end
         end
      end
   end

   initial begin
      fifo_head = 0;
      fifo_level = 0;
      work_byte = 8'h00;
      bits_left = '0;
      send_idle_pct <= 37;
      recv_idle_pct <= 88;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty queue, zero-length read, no-op, stuffing,
      // marker, skip hits and misses, whole-byte path, oversized count.
      read_bits(5, 1'b1);
      skip_to(8'h00, 1'b0);
      read_bits(8, 1'b0);
      skip_to(8'h77, 1'b1);
      read_bits(0, 1'b1);
      add_cmd(jbr_pkg::FUNC_NOP, 255, 63, 1'b1, 255);
      push_byte(8'h12);
      push_byte(jbr_pkg::MARKER_PREFIX);
      push_byte(jbr_pkg::STUFF_BYTE);
      push_byte(8'hA5);
      push_byte(jbr_pkg::MARKER_PREFIX);
      push_byte(8'hD9);
      push_byte(8'h34);
      push_byte(8'h56);
      push_byte(8'h78);
      push_byte(jbr_pkg::MARKER_PREFIX);
      read_bits(12, 1'b1);
      read_bits(20, 1'b1);
      skip_to(8'h56, 1'b0);
      read_bits(16, 1'b0);
      skip_to(8'h56, 1'b1);
      read_bits(63, 1'b0);
      read_bits(32, 1'b0);
      push_byte(8'h00);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct <= 88;
            recv_idle_pct <= 37;
         end else if (phase == 2) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         cmds_added = 0;
         while (cmds_added < PER_PHASE) add_burst();
         while (cmd_queue.size() != 0) @(posedge clock);
      end

      while (cmd_queue.size() != 0 || req_tvalid || reply_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && reply_queue.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("ERROR: timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
